[hw/rtl/asw_pkg.sv]
// Package for the admitted-sender window average block.
// Holds shared widths, default sizes, the control state type and the lookup status struct.
// No dependencies.
package asw_pkg;

  localparam int DEF_SENDER_SLOTS = 10;
  localparam int DEF_WINDOW       = 10;
  localparam int ADDR_HALF_W      = 64;
  localparam int VALUE_W          = 16;
  localparam int FRAC_W           = 8;
  localparam int MEAN_W           = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WINDOW,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic done;
    logic accept;
    logic admitted;
  } lookup_res_t;

endpackage

[hw/rtl/asw_lookup.sv]
// Sender table: a 128-bit wide memory scanned one entry per cycle, plus the fill count.
// Admits unknown senders while the table has room.
// Depends on asw_pkg.
module asw_lookup #(
  parameter int SENDER_SLOTS = asw_pkg::DEF_SENDER_SLOTS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [asw_pkg::ADDR_HALF_W-1:0]    key_high,
  input  logic [asw_pkg::ADDR_HALF_W-1:0]    key_low,
  output asw_pkg::lookup_res_t               res
);
  import asw_pkg::*;

  localparam int CNT_W = $clog2(SENDER_SLOTS + 1);
  localparam int IDX_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(SENDER_SLOTS);

  logic [2*ADDR_HALF_W-1:0] mem [SENDER_SLOTS];
  logic [2*ADDR_HALF_W-1:0] rd_data_r;
  logic [2*ADDR_HALF_W-1:0] key;
  logic                     busy_r, busy_nxt;
  logic                     pend_r, pend_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic                     hit, at_end, full, issue, write_en;

  always_comb begin
    key      = {key_high, key_low};
    hit      = pend_r && (rd_data_r == key);
    at_end   = (idx_r == count_r);
    full     = (count_r == FULL);
    issue    = busy_r && !hit && !at_end;
    res.done     = busy_r && (hit || at_end);
    res.accept   = !full || hit;
    res.admitted = !full && !hit;
    write_en = res.done && res.admitted;
  end

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    pend_nxt  = issue;
    if (start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (res.done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
    if (write_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      pend_r  <= pend_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      mem[count_r[IDX_W-1:0]] <= key;
    end
    if (issue) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

endmodule

[hw/rtl/asw_window.sv]
// Window ring: a sample memory with per-slot valid bits, the write position,
// the running total and the count of nonzero slots. Depends on asw_pkg.
module asw_window #(
  parameter int WINDOW = asw_pkg::DEF_WINDOW,
  localparam int TOT_W = $clog2(WINDOW * (2 ** asw_pkg::VALUE_W - 1) + 1),
  localparam int NZ_W  = $clog2(WINDOW + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [asw_pkg::VALUE_W-1:0]   sample,
  output logic                          done,
  output logic [TOT_W-1:0]              total,
  output logic [NZ_W-1:0]               nonzero
);
  import asw_pkg::*;

  localparam int WP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [WP_W-1:0] LAST = WP_W'(WINDOW - 1);

  logic [VALUE_W-1:0] mem [WINDOW];
  logic [VALUE_W-1:0] rd_data_r;
  logic [WINDOW-1:0]  valid_r;
  logic               pend_r;
  logic               done_r;
  logic [WP_W-1:0]    wpos_r, wpos_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [NZ_W-1:0]    nz_r, nz_nxt;
  logic [VALUE_W-1:0] old;

  always_comb begin
    old       = valid_r[wpos_r] ? rd_data_r : '0;
    total_nxt = total_r - TOT_W'(old) + TOT_W'(sample);
    nz_nxt    = nz_r - NZ_W'(old != '0) + NZ_W'(sample != '0);
    wpos_nxt  = (wpos_r == LAST) ? '0 : wpos_r + WP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      wpos_r  <= '0;
      total_r <= '0;
      nz_r    <= '0;
    end else begin
      pend_r <= start;
      done_r <= pend_r;
      if (pend_r) begin
        valid_r[wpos_r] <= 1'b1;
        wpos_r          <= wpos_nxt;
        total_r         <= total_nxt;
        nz_r            <= nz_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_data_r <= mem[wpos_r];
    end
    if (pend_r) begin
      mem[wpos_r] <= sample;
    end
  end

  assign done    = done_r;
  assign total   = total_r;
  assign nonzero = nz_r;

endmodule

[hw/rtl/asw_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Used for the window mean. Depends on asw_pkg only through its caller.
module asw_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] step_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = !diff[DVS_W];
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - CNT_W'(1);
        if (step_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/admitted_sender_window_average.sv]
// Phases: a lookup that compares n table entries (n at most the fill count), a window
// update, a divide when any slot is nonzero, and an output load. A rejected item skips the
// window and the divide; a window that holds only zeros skips the divide.
// One item at a time; the output register lets the next item enter while a result waits.
// Reset (synchronous, active low) empties the sender table and clears the window at once.
module admitted_sender_window_average #(
  parameter int SENDER_SLOTS = asw_pkg::DEF_SENDER_SLOTS,
  parameter int WINDOW       = asw_pkg::DEF_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [asw_pkg::ADDR_HALF_W-1:0] in_sender_address_high,
  input  logic [asw_pkg::ADDR_HALF_W-1:0] in_sender_address_low,
  input  logic [asw_pkg::VALUE_W-1:0]     in_sample_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic                            out_newly_admitted,
  output logic [asw_pkg::MEAN_W-1:0]      out_mean_value,
  output logic                            out_mean_valid
);
  import asw_pkg::*;

  localparam int TOT_W = $clog2(WINDOW * (2 ** VALUE_W - 1) + 1);
  localparam int NZ_W  = $clog2(WINDOW + 1);
  localparam int DVD_W = TOT_W + FRAC_W;

  state_t               state_r, state_nxt;
  logic [ADDR_HALF_W-1:0] hi_r, lo_r;
  logic [VALUE_W-1:0]   sample_r;
  logic                 acc_r, adm_r, mvalid_r;
  logic [MEAN_W-1:0]    mean_r;
  logic                 out_valid_r;
  logic                 out_acc_r, out_adm_r, out_mvalid_r;
  logic [MEAN_W-1:0]    out_mean_r;
  lookup_res_t          lk;
  logic                 win_done;
  logic [TOT_W-1:0]     total;
  logic [NZ_W-1:0]      nonzero;
  logic                 div_done;
  logic [DVD_W-1:0]     quotient;
  logic                 lk_start, win_start, div_start, out_load;

  asw_lookup #(.SENDER_SLOTS(SENDER_SLOTS)) u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (lk_start),
    .key_high (hi_r),
    .key_low  (lo_r),
    .res      (lk)
  );

  asw_window #(.WINDOW(WINDOW)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (win_start),
    .sample  (sample_r),
    .done    (win_done),
    .total   (total),
    .nonzero (nonzero)
  );

  asw_div #(.DVD_W(DVD_W), .DVS_W(NZ_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({total, FRAC_W'(0)}),
    .divisor  (nonzero),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (lk.done) state_nxt = lk.accept ? ST_WINDOW : ST_OUTPUT;
      end
      ST_WINDOW: begin
        if (win_done) state_nxt = (nonzero != '0) ? ST_DIVIDE : ST_OUTPUT;
      end
      ST_DIVIDE: begin
        if (div_done) state_nxt = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    lk_start  = in_ready && in_valid;
    win_start = (state_r == ST_LOOKUP) && lk.done && lk.accept;
    div_start = (state_r == ST_WINDOW) && win_done && (nonzero != '0);
    out_load  = (state_r == ST_OUTPUT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lk_start) begin
      hi_r     <= in_sender_address_high;
      lo_r     <= in_sender_address_low;
      sample_r <= in_sample_value;
    end
    if ((state_r == ST_LOOKUP) && lk.done) begin
      acc_r    <= lk.accept;
      adm_r    <= lk.admitted;
      mean_r   <= '0;
      mvalid_r <= 1'b0;
    end
    if (div_start) begin
      mvalid_r <= 1'b1;
    end
    if (div_done) begin
      mean_r <= quotient[MEAN_W-1:0];
    end
    if (out_load) begin
      out_acc_r    <= acc_r;
      out_adm_r    <= adm_r;
      out_mean_r   <= mean_r;
      out_mvalid_r <= mvalid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_newly_admitted = out_adm_r;
  assign out_mean_value     = out_mean_r;
  assign out_mean_valid     = out_mvalid_r;

`ifndef NO_ASSERTIONS
  a_admit_implies_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_newly_admitted |-> out_accepted)
    else $error("newly admitted sender reported as rejected");

  a_reject_zero_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> !out_mean_valid && (out_mean_value == '0))
    else $error("rejected item carries a mean");

  a_lookup_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    lk.done |-> state_r == ST_LOOKUP)
    else $error("sender lookup finished outside its phase");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIVIDE)
    else $error("divider finished outside its phase");
`endif

endmodule

[bench/admitted_sender_window_average_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the admitted-sender window average block: drives sensor items,
// predicts table admission and the nonzero-slot mean, and checks every result in order.
// Depends on asw_pkg and the admitted_sender_window_average RTL.
module admitted_sender_window_average_test;
  import asw_pkg::*;

  localparam int SENDERS = DEF_SENDER_SLOTS;
  localparam int SLOTS   = DEF_WINDOW;

  typedef struct {
    logic              accepted;
    logic              newly_admitted;
    logic [MEAN_W-1:0] mean_value;
    logic              mean_valid;
  } average_result_t;

  class average_scoreboard;
    logic [ADDR_HALF_W-1:0] table_hi[SENDERS];
    logic [ADDR_HALF_W-1:0] table_lo[SENDERS];
    int unsigned            senders_known;
    logic [VALUE_W-1:0]     ring[SLOTS];
    int unsigned            ring_pos;
    int unsigned            ring_total;
    int unsigned            ring_nonzero;
    average_result_t        expected_averages[$];
    int unsigned            errors;

    function new();
      senders_known = 0;
      ring_pos = 0;
      ring_total = 0;
      ring_nonzero = 0;
      errors = 0;
      foreach (ring[k]) ring[k] = '0;
    endfunction

    function int unsigned outstanding();
      return expected_averages.size();
    endfunction

    function void predict_reading(logic [ADDR_HALF_W-1:0] hi, logic [ADDR_HALF_W-1:0] lo,
                                  logic [VALUE_W-1:0] value);
      average_result_t r;
      logic            known;
      logic [31:0]     scaled;
      known = 1'b0;
      r.accepted = 1'b0;
      r.newly_admitted = 1'b0;
      r.mean_value = '0;
      r.mean_valid = 1'b0;
      for (int k = 0; k < senders_known; k++) begin
        if (table_hi[k] == hi && table_lo[k] == lo) known = 1'b1;
      end
      if (senders_known < SENDERS) begin
        r.accepted = 1'b1;
        if (!known) begin
          table_hi[senders_known] = hi;
          table_lo[senders_known] = lo;
          senders_known++;
          r.newly_admitted = 1'b1;
        end
      end else begin
        r.accepted = known;
      end
      if (r.accepted) begin
        ring_total -= 32'(ring[ring_pos]);
        if (ring[ring_pos] != 0) ring_nonzero--;
        ring[ring_pos] = value;
        ring_total += 32'(value);
        if (value != 0) ring_nonzero++;
        ring_pos = (ring_pos + 1 == SLOTS) ? 0 : ring_pos + 1;
        if (ring_nonzero != 0) begin
          scaled = (ring_total << FRAC_W) / ring_nonzero;
          r.mean_value = scaled[MEAN_W-1:0];
          r.mean_valid = 1'b1;
        end
      end
      expected_averages.push_back(r);
    endfunction

    function void compare_field(string field, logic [MEAN_W-1:0] exp_v,
                                logic [MEAN_W-1:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_average(logic acc, logic adm, logic [MEAN_W-1:0] mean, logic mv);
      average_result_t r;
      if (expected_averages.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual mean %0h", $time, mean);
        return;
      end
      r = expected_averages.pop_front();
      compare_field("accepted", MEAN_W'(r.accepted), MEAN_W'(acc));
      compare_field("newly_admitted", MEAN_W'(r.newly_admitted), MEAN_W'(adm));
      compare_field("mean_value", r.mean_value, mean);
      compare_field("mean_valid", MEAN_W'(r.mean_valid), MEAN_W'(mv));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ADDR_HALF_W-1:0] in_sender_address_high = '0;
  logic [ADDR_HALF_W-1:0] in_sender_address_low = '0;
  logic [VALUE_W-1:0]     in_sample_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_accepted;
  logic                   out_newly_admitted;
  logic [MEAN_W-1:0]      out_mean_value;
  logic                   out_mean_valid;

  average_scoreboard      sb = new();
  int unsigned            send_idle = 16;
  int unsigned            recv_idle = 65;
  logic [ADDR_HALF_W-1:0] known_hi[SENDERS];
  logic [ADDR_HALF_W-1:0] known_lo[SENDERS];

  admitted_sender_window_average dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sender_address_high(in_sender_address_high),
    .in_sender_address_low(in_sender_address_low),
    .in_sample_value(in_sample_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_newly_admitted(out_newly_admitted),
    .out_mean_value(out_mean_value), .out_mean_valid(out_mean_valid)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.predict_reading(in_sender_address_high, in_sender_address_low, in_sample_value);
    end
    if (rst_n && out_valid && out_ready) begin
      sb.check_average(out_accepted, out_newly_admitted, out_mean_value, out_mean_valid);
    end
  end

  task automatic send_reading(input logic [ADDR_HALF_W-1:0] hi,
                              input logic [ADDR_HALF_W-1:0] lo,
                              input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sender_address_high <= hi;
    in_sender_address_low <= lo;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic send_random_readings(input int count);
    logic [ADDR_HALF_W-1:0] hi;
    logic [ADDR_HALF_W-1:0] lo;
    logic [VALUE_W-1:0]     value;
    int unsigned            pick;
    int unsigned            k;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      pick = $urandom_range(99);
      k = $urandom_range(SENDERS - 1);
      hi = known_hi[k];
      lo = known_lo[k];
      if (pick >= 92) begin
        if ($urandom_range(1)) hi[$urandom_range(ADDR_HALF_W - 1)] ^= 1'b1;
        else lo[$urandom_range(ADDR_HALF_W - 1)] ^= 1'b1;
      end else if (pick >= 78) begin
        hi = {$urandom, $urandom};
        lo = {$urandom, $urandom};
      end
      pick = $urandom_range(99);
      if (pick < 15) value = '0;
      else if (pick < 25) value = '1;
      else value = VALUE_W'($urandom);
      send_reading(hi, lo, value);
    end
  endtask

  initial begin
    known_hi[0] = '0;
    known_lo[0] = '0;
    known_hi[1] = '1;
    known_lo[1] = '1;
    known_hi[2] = '1;
    known_lo[2] = '0;
    known_hi[3] = '0;
    known_lo[3] = '1;
    for (int k = 4; k < SENDERS; k++) begin
      known_hi[k] = {$urandom, $urandom};
      known_lo[k] = {$urandom, $urandom};
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the table, including a repeat from a sender that is already known.
    send_reading(known_hi[0], known_lo[0], 16'h0000);
    send_reading(known_hi[0], known_lo[0], 16'hFFFF);
    send_reading(known_hi[1], known_lo[1], 16'hFFFF);
    send_reading(known_hi[2], known_lo[2], 16'h0001);
    send_reading(known_hi[3], known_lo[3], 16'h0000);
    send_reading(known_hi[4], known_lo[4], 16'h8000);
    send_reading(known_hi[5], known_lo[5], 16'h7FFF);
    send_reading(known_hi[6], known_lo[6], 16'hFFFF);
    send_reading(known_hi[7], known_lo[7], 16'h0002);
    send_reading(known_hi[8], known_lo[8], 16'hFFFF);
    send_reading(known_hi[9], known_lo[9], 16'h1234);
    // The table is full now, so strangers and near misses are turned away.
    send_reading('1, {{(ADDR_HALF_W-1){1'b1}}, 1'b0}, 16'hFFFF);
    send_reading(known_hi[5], known_lo[6], 16'h4321);
    // Zero the whole window, then leave a single full-scale reading.
    for (int k = 0; k < SLOTS; k++) send_reading(known_hi[k], known_lo[k], 16'h0000);
    send_reading(known_hi[1], known_lo[1], 16'hFFFF);

    send_idle = 16;
    recv_idle = 65;
    send_random_readings(460);
    drain_results();
    send_idle = 65;
    recv_idle = 16;
    send_random_readings(460);
    drain_results();
    send_idle = 0;
    recv_idle = 0;
    send_random_readings(460);
    drain_results();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("tb: failure");
    $finish;
  end

endmodule
